/* design/sbdt_pkg.sv */
// ----------------------------------------------------------------------------
// sbdt_pkg
// Shared types, widths and codes of the shared-buffer accounting block.
// ----------------------------------------------------------------------------
package sbdt_pkg;

  // Sizing of the accounting stores
  localparam int NUM_QUEUES     = 8;
  localparam int NUM_PORTS      = 16;
  localparam int NUM_PRIORITIES = 8;

  localparam int QUEUE_AW = (NUM_QUEUES > 1)     ? $clog2(NUM_QUEUES)     : 1;
  localparam int PORT_AW  = (NUM_PORTS > 1)      ? $clog2(NUM_PORTS)      : 1;
  localparam int PRIO_AW  = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int BYTES_W    = 16;
  localparam int QUEUE_W    = 3;
  localparam int PORT_W     = 4;
  localparam int PRIO_W     = 3;
  localparam int CNT_W      = 24;
  localparam int SATC_W     = 8;
  localparam int ALPHA_W    = 8;
  localparam int LIM_SHIFT  = 4;
  localparam int PROD_W     = ALPHA_W + CNT_W;
  localparam int LIMIT_W    = PROD_W - LIM_SHIFT;
  localparam int TABLE_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Register reset values
  localparam logic [CNT_W-1:0]   MAX_BUFFER_RST  = 24'd10000;
  localparam logic [TABLE_W-1:0] QUEUE_ALPHA_RST = 64'h1010_1010_1010_1010;
  localparam logic [TABLE_W-1:0] PRIO_ALPHA_RST  = 64'hA0A0_A0A0_A0A0_A0A0;
  localparam logic [CNT_W-1:0]   QPRIO_MAP_RST   = 24'hFAC688;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [SATC_W-1:0] SATC_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ   = 2'd0,
    FUNC_DEQ   = 2'd1,
    FUNC_SAT   = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BUFFER  = 2'd0,
    CFG_QUEUE_ALPHA = 2'd1,
    CFG_PRIO_ALPHA  = 2'd2,
    CFG_QPRIO_MAP   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LIMIT,
    ST_DONE
  } state_t;

  // One accounting operation, decoded at accept time
  typedef struct packed {
    func_t               func;
    logic [BYTES_W-1:0]  bytes;
    logic [QUEUE_W-1:0]  queue;
    logic [PRIO_W-1:0]   prio;
    logic [PORT_W-1:0]   port;
    logic                lvl;
    logic                ok;
    logic                port_ok;
  } op_t;

  // Counters after the operation
  typedef struct packed {
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  prio_used;
    logic [SATC_W-1:0] sat_cnt;
    logic              err;
  } acct_res_t;

endpackage

/* design/sbdt_ram.sv */
// ----------------------------------------------------------------------------
// sbdt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sbdt_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/sbdt_acct.sv */
// ----------------------------------------------------------------------------
// sbdt_acct
// Byte and saturation accounting: reads the per-priority and per-port
// entries, applies the operation with saturation, and writes them back.
// ----------------------------------------------------------------------------
module sbdt_acct (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sbdt_pkg::op_t      op,
  output sbdt_pkg::acct_res_t res
);

  import sbdt_pkg::*;

  op_t                  op_r;
  logic                 upd_r;
  logic [CNT_W-1:0]     total_r, total_nxt;
  acct_res_t            res_r, res_nxt;

  logic [NUM_PRIORITIES-1:0] used_vld_r;
  logic [NUM_PORTS-1:0]      satb_vld_r;
  logic [NUM_PRIORITIES-1:0] satc_vld_r;
  logic                      used_hit_r, satb_hit_r, satc_hit_r;

  logic [CNT_W-1:0]      used_rd, used_old, used_new;
  logic [NUM_QUEUES-1:0] satb_rd, satb_old, satb_new;
  logic [SATC_W-1:0]     satc_rd, satc_old, satc_new;
  logic                  used_we, satb_we, satc_we, err_nxt;
  logic [CNT_W:0]        tot_add, used_add;

  logic [PRIO_AW-1:0]  rd_prio, wr_prio;
  logic [PORT_AW-1:0]  rd_port, wr_port;
  logic [QUEUE_AW-1:0] qbit;

  assign rd_prio = PRIO_AW'(op.prio);
  assign rd_port = PORT_AW'(op.port);
  assign wr_prio = PRIO_AW'(op_r.prio);
  assign wr_port = PORT_AW'(op_r.port);
  assign qbit    = QUEUE_AW'(op_r.queue);

  sbdt_ram #(.DATA_W(CNT_W), .DEPTH(NUM_PRIORITIES)) u_used_ram (
    .clk     (clk),
    .wr_en   (used_we),
    .wr_addr (wr_prio),
    .wr_data (used_new),
    .rd_en   (start),
    .rd_addr (rd_prio),
    .rd_data (used_rd)
  );

  sbdt_ram #(.DATA_W(NUM_QUEUES), .DEPTH(NUM_PORTS)) u_satb_ram (
    .clk     (clk),
    .wr_en   (satb_we),
    .wr_addr (wr_port),
    .wr_data (satb_new),
    .rd_en   (start),
    .rd_addr (rd_port),
    .rd_data (satb_rd)
  );

  sbdt_ram #(.DATA_W(SATC_W), .DEPTH(NUM_PRIORITIES)) u_satc_ram (
    .clk     (clk),
    .wr_en   (satc_we),
    .wr_addr (wr_prio),
    .wr_data (satc_new),
    .rd_en   (start),
    .rd_addr (rd_prio),
    .rd_data (satc_rd)
  );

  // Entries never written since reset read as zero
  assign used_old = used_hit_r ? used_rd : '0;
  assign satb_old = satb_hit_r ? satb_rd : '0;
  assign satc_old = satc_hit_r ? satc_rd : '0;

  assign tot_add  = {1'b0, total_r}  + (CNT_W+1)'(op_r.bytes);
  assign used_add = {1'b0, used_old} + (CNT_W+1)'(op_r.bytes);

  always_comb begin
    total_nxt = total_r;
    used_new  = used_old;
    satb_new  = satb_old;
    satc_new  = satc_old;
    used_we   = 1'b0;
    satb_we   = 1'b0;
    satc_we   = 1'b0;
    err_nxt   = 1'b0;
    if (upd_r && op_r.ok) begin
      case (op_r.func)
        FUNC_ENQ: begin
          used_we = 1'b1;
          if (tot_add > {1'b0, CNT_MAX}) begin
            total_nxt = CNT_MAX;
            err_nxt   = 1'b1;
          end else begin
            total_nxt = tot_add[CNT_W-1:0];
          end
          if (used_add > {1'b0, CNT_MAX}) begin
            used_new = CNT_MAX;
            err_nxt  = 1'b1;
          end else begin
            used_new = used_add[CNT_W-1:0];
          end
        end
        FUNC_DEQ: begin
          used_we = 1'b1;
          if (CNT_W'(op_r.bytes) > total_r) begin
            total_nxt = '0;
            err_nxt   = 1'b1;
          end else begin
            total_nxt = total_r - CNT_W'(op_r.bytes);
          end
          if (CNT_W'(op_r.bytes) > used_old) begin
            used_new = '0;
            err_nxt  = 1'b1;
          end else begin
            used_new = used_old - CNT_W'(op_r.bytes);
          end
        end
        FUNC_SAT: begin
          // Only a real change of the bit moves the count
          if (op_r.port_ok && (satb_old[qbit] != op_r.lvl)) begin
            satb_we        = 1'b1;
            satc_we        = 1'b1;
            satb_new[qbit] = op_r.lvl;
            if (op_r.lvl) begin
              if (satc_old == SATC_MAX) begin
                err_nxt = 1'b1;
              end else begin
                satc_new = satc_old + SATC_W'(1);
              end
            end else begin
              if (satc_old == '0) begin
                err_nxt = 1'b1;
              end else begin
                satc_new = satc_old - SATC_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_nxt.total     = total_nxt;
    res_nxt.prio_used = op_r.ok ? used_new : '0;
    res_nxt.sat_cnt   = op_r.ok ? satc_new : '0;
    res_nxt.err       = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r      <= 1'b0;
      total_r    <= '0;
      used_vld_r <= '0;
      satb_vld_r <= '0;
      satc_vld_r <= '0;
    end else begin
      upd_r   <= start;
      total_r <= total_nxt;
      if (used_we) used_vld_r[wr_prio] <= 1'b1;
      if (satb_we) satb_vld_r[wr_port] <= 1'b1;
      if (satc_we) satc_vld_r[wr_prio] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r       <= op;
      used_hit_r <= used_vld_r[rd_prio];
      satb_hit_r <= satb_vld_r[rd_port];
      satc_hit_r <= satc_vld_r[rd_prio];
    end
    if (upd_r) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

/* design/sbdt_limit.sv */
// ----------------------------------------------------------------------------
// sbdt_limit
// Dynamic thresholds: alpha (Q4.4) times free buffer space, truncated.
// ----------------------------------------------------------------------------
module sbdt_limit (
  input  logic                          clk,
  input  logic                          load,
  input  logic [sbdt_pkg::CNT_W-1:0]    max_buf,
  input  logic [sbdt_pkg::CNT_W-1:0]    total,
  input  logic [sbdt_pkg::ALPHA_W-1:0]  queue_alpha,
  input  logic [sbdt_pkg::ALPHA_W-1:0]  prio_alpha,
  output logic [sbdt_pkg::LIMIT_W-1:0]  queue_limit,
  output logic [sbdt_pkg::LIMIT_W-1:0]  priority_limit
);

  import sbdt_pkg::*;

  logic [CNT_W-1:0]  free_space;
  logic [PROD_W-1:0] qprod_r, pprod_r;

  // Clamp to zero when the buffer is full or over-committed
  assign free_space = (total >= max_buf) ? '0 : (max_buf - total);

  always_ff @(posedge clk) begin
    if (load) begin
      qprod_r <= PROD_W'(queue_alpha) * PROD_W'(free_space);
      pprod_r <= PROD_W'(prio_alpha) * PROD_W'(free_space);
    end
  end

  assign queue_limit    = qprod_r[PROD_W-1:LIM_SHIFT];
  assign priority_limit = pprod_r[PROD_W-1:LIM_SHIFT];

endmodule

/* design/shared_buffer_dynamic_threshold_top.sv */
// ----------------------------------------------------------------------------
// shared_buffer_dynamic_threshold_top
// Shared-buffer accounting with dynamic thresholds for a switch.
//
// Input channel (in_valid/in_ready): one beat is an enqueue, dequeue,
// saturation update or query. Result channel (out_valid/out_ready): one
// beat per input beat, in order, with the counters after the operation
// and the queue and priority thresholds.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index at once;
// write only while no beat is in flight.
// Sequencing: a beat is taken only in the idle state, and the next one only
// after the read-modify-write of the accounting RAMs (read, update and
// write back) and the registered threshold multiply are through.
// The output register holds a finished result, so a new beat is taken
// while the receiver stalls; the next result then waits for the slot.
// Reset: registers return to their defaults and all counters read as zero
// at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shared_buffer_dynamic_threshold_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [sbdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sbdt_pkg::FUNC_W-1:0]      in_func,
  input  logic [sbdt_pkg::BYTES_W-1:0]     in_byte_count,
  input  logic [sbdt_pkg::QUEUE_W-1:0]     in_queue_index,
  input  logic [sbdt_pkg::PORT_W-1:0]      in_port_index,
  input  logic                             in_sat_level,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sbdt_pkg::CNT_W-1:0]       out_total_used,
  output logic [sbdt_pkg::CNT_W-1:0]       out_priority_used,
  output logic [sbdt_pkg::LIMIT_W-1:0]     out_queue_limit,
  output logic [sbdt_pkg::LIMIT_W-1:0]     out_priority_limit,
  output logic [sbdt_pkg::SATC_W-1:0]      out_saturated_count,
  output logic                             out_count_error
);

  import sbdt_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   max_buffer_r;
  logic [TABLE_W-1:0] queue_alpha_r;
  logic [TABLE_W-1:0] prio_alpha_r;
  logic [CNT_W-1:0]   qprio_map_r;

  logic [ALPHA_W-1:0] qa_r, pa_r;
  logic [PRIO_W-1:0]  in_prio;
  op_t                op;
  acct_res_t          acct_res;

  logic               accept, lim_load, out_load;
  logic [LIMIT_W-1:0] qlim, plim;

  logic               out_valid_r;
  logic [CNT_W-1:0]   out_total_r, out_prio_used_r;
  logic [LIMIT_W-1:0] out_qlim_r, out_plim_r;
  logic [SATC_W-1:0]  out_satc_r;
  logic               out_err_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_buffer_r  <= MAX_BUFFER_RST;
      queue_alpha_r <= QUEUE_ALPHA_RST;
      prio_alpha_r  <= PRIO_ALPHA_RST;
      qprio_map_r   <= QPRIO_MAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MAX_BUFFER:  max_buffer_r  <= cfg_data[CNT_W-1:0];
        CFG_QUEUE_ALPHA: queue_alpha_r <= cfg_data[TABLE_W-1:0];
        CFG_PRIO_ALPHA:  prio_alpha_r  <= cfg_data[TABLE_W-1:0];
        CFG_QPRIO_MAP:   qprio_map_r   <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Decode the incoming beat
  assign in_prio    = qprio_map_r[PRIO_W*in_queue_index +: PRIO_W];
  assign op.func    = func_t'(in_func);
  assign op.bytes   = in_byte_count;
  assign op.queue   = in_queue_index;
  assign op.prio    = in_prio;
  assign op.port    = in_port_index;
  assign op.lvl     = in_sat_level;
  assign op.ok      = (int'(in_queue_index) < NUM_QUEUES) &&
                      (int'(in_prio) < NUM_PRIORITIES);
  assign op.port_ok = int'(in_port_index) < NUM_PORTS;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      qa_r <= queue_alpha_r[ALPHA_W*in_queue_index +: ALPHA_W];
      pa_r <= prio_alpha_r[ALPHA_W*in_prio +: ALPHA_W];
    end
  end

  sbdt_acct u_acct (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .op    (op),
    .res   (acct_res)
  );

  sbdt_limit u_limit (
    .clk            (clk),
    .load           (lim_load),
    .max_buf        (max_buffer_r),
    .total          (acct_res.total),
    .queue_alpha    (qa_r),
    .prio_alpha     (pa_r),
    .queue_limit    (qlim),
    .priority_limit (plim)
  );

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_LIMIT;
      ST_LIMIT:  state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    lim_load = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_LIMIT: lim_load = 1'b1;
      ST_DONE:  out_load = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output slot: hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_total_r     <= acct_res.total;
      out_prio_used_r <= acct_res.prio_used;
      out_qlim_r      <= qlim;
      out_plim_r      <= plim;
      out_satc_r      <= acct_res.sat_cnt;
      out_err_r       <= acct_res.err;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_total_used      = out_total_r;
  assign out_priority_used   = out_prio_used_r;
  assign out_queue_limit     = out_qlim_r;
  assign out_priority_limit  = out_plim_r;
  assign out_saturated_count = out_satc_r;
  assign out_count_error     = out_err_r;

  // Only one beat in flight through the accounting RAMs
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken while an update is in flight");

  a_update_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> $past(accept))
    else $error("update state without a taken beat");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result presented outside the done state");

  a_result_before_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && (!out_valid_r || out_ready) |=> out_valid_r && in_ready)
    else $error("finished result not loaded into the output slot");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shared-buffer accounting block. A scoreboard
// class keeps its own copy of the buffer counters, saturation bits and
// registers, predicts the counters and thresholds of every accepted beat and
// checks each result beat in order. Stimulus covers a directed opening, random
// phases under extreme and random register settings, a total-counter overflow
// run, a saturation-count drift run across map changes and a closing phase
// with no idling.
// ----------------------------------------------------------------------------
module tb_top;
  import sbdt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [CNT_W-1:0] MAP_ALL_PRIO0 = 24'h000000;
  localparam logic [CNT_W-1:0] MAP_ALL_PRIO1 = 24'h249249;

  typedef struct packed {
    func_t              func;
    logic [BYTES_W-1:0] bytes;
    logic [QUEUE_W-1:0] queue;
    logic [PORT_W-1:0]  port;
    logic               lvl;
  } acct_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0]   total_used;
    logic [CNT_W-1:0]   priority_used;
    logic [LIMIT_W-1:0] queue_limit;
    logic [LIMIT_W-1:0] priority_limit;
    logic [SATC_W-1:0]  saturated_count;
    logic               count_error;
  } acct_report_t;

  class acct_scoreboard;
    logic [CNT_W-1:0]      max_buffer;
    logic [TABLE_W-1:0]    queue_alpha;
    logic [TABLE_W-1:0]    prio_alpha;
    logic [CNT_W-1:0]      qprio_map;
    logic [CNT_W-1:0]      total;
    logic [CNT_W-1:0]      used_prio[NUM_PRIORITIES];
    logic [NUM_QUEUES-1:0] sat_bits[NUM_PORTS];
    logic [SATC_W-1:0]     sat_cnt[NUM_PRIORITIES];
    acct_report_t          expected_q[$];
    int                    mismatches;

    function new();
      max_buffer  = MAX_BUFFER_RST;
      queue_alpha = QUEUE_ALPHA_RST;
      prio_alpha  = PRIO_ALPHA_RST;
      qprio_map   = QPRIO_MAP_RST;
      total       = '0;
      foreach (used_prio[i]) used_prio[i] = '0;
      foreach (sat_bits[i]) sat_bits[i] = '0;
      foreach (sat_cnt[i]) sat_cnt[i] = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAX_BUFFER:  max_buffer  = data[CNT_W-1:0];
        CFG_QUEUE_ALPHA: queue_alpha = data[TABLE_W-1:0];
        CFG_PRIO_ALPHA:  prio_alpha  = data[TABLE_W-1:0];
        CFG_QPRIO_MAP:   qprio_map   = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] add_clip(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b,
                                        logic [CNT_W-1:0] top, inout logic err);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum > {1'b0, top}) begin
        err = 1'b1;
        return top;
      end
      return sum[CNT_W-1:0];
    endfunction

    function logic [CNT_W-1:0] sub_clip(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b,
                                        inout logic err);
      if (b > a) begin
        err = 1'b1;
        return '0;
      end
      return a - b;
    endfunction

    // alpha is Q4.4: drop the four fraction bits, zero once the buffer is full
    function logic [LIMIT_W-1:0] threshold(logic [ALPHA_W-1:0] alpha);
      logic [PROD_W-1:0] prod;
      if (total >= max_buffer) return '0;
      prod = PROD_W'(alpha) * PROD_W'(max_buffer - total);
      return prod[PROD_W-1:LIM_SHIFT];
    endfunction

    function void note_input(acct_beat_t b);
      logic [PRIO_W-1:0] p;
      logic              ok;
      logic              err;
      acct_report_t      r;
      p   = qprio_map[PRIO_W*b.queue +: PRIO_W];
      ok  = (int'(b.queue) < NUM_QUEUES) && (int'(p) < NUM_PRIORITIES);
      err = 1'b0;
      if (ok) begin
        case (b.func)
          FUNC_ENQ: begin
            total        = add_clip(total, CNT_W'(b.bytes), CNT_MAX, err);
            used_prio[p] = add_clip(used_prio[p], CNT_W'(b.bytes), CNT_MAX, err);
          end
          FUNC_DEQ: begin
            total        = sub_clip(total, CNT_W'(b.bytes), err);
            used_prio[p] = sub_clip(used_prio[p], CNT_W'(b.bytes), err);
          end
          FUNC_SAT: begin
            // count against the priority mapped now, even if the bit was set under another
            if (int'(b.port) < NUM_PORTS && sat_bits[b.port][b.queue] != b.lvl) begin
              if (b.lvl)
                sat_cnt[p] = SATC_W'(add_clip(CNT_W'(sat_cnt[p]), CNT_W'(1),
                                              CNT_W'(SATC_MAX), err));
              else
                sat_cnt[p] = SATC_W'(sub_clip(CNT_W'(sat_cnt[p]), CNT_W'(1), err));
              sat_bits[b.port][b.queue] = b.lvl;
            end
          end
          default: ;
        endcase
      end
      r.total_used      = total;
      r.priority_used   = ok ? used_prio[p] : '0;
      r.queue_limit     = threshold(queue_alpha[ALPHA_W*b.queue +: ALPHA_W]);
      r.priority_limit  = threshold(prio_alpha[ALPHA_W*p +: ALPHA_W]);
      r.saturated_count = ok ? sat_cnt[p] : '0;
      r.count_error     = err;
      expected_q.push_back(r);
    endfunction

    function void check_result(acct_report_t got);
      acct_report_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result beat with nothing outstanding: total %h", $realtime,
                   got.total_used);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result mismatch (exp/got):", $realtime);
            $display("  total_used %h/%h priority_used %h/%h",
                     want.total_used, got.total_used, want.priority_used, got.priority_used);
            $display("  queue_limit %h/%h priority_limit %h/%h",
                     want.queue_limit, got.queue_limit,
                     want.priority_limit, got.priority_limit);
            $display("  saturated_count %h/%h count_error %b/%b",
                     want.saturated_count, got.saturated_count,
                     want.count_error, got.count_error);
          end
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func;
  logic [BYTES_W-1:0]    in_byte_count;
  logic [QUEUE_W-1:0]    in_queue_index;
  logic [PORT_W-1:0]     in_port_index;
  logic                  in_sat_level;
  logic                  out_valid;
  logic                  out_ready;
  logic [CNT_W-1:0]      out_total_used;
  logic [CNT_W-1:0]      out_priority_used;
  logic [LIMIT_W-1:0]    out_queue_limit;
  logic [LIMIT_W-1:0]    out_priority_limit;
  logic [SATC_W-1:0]     out_saturated_count;
  logic                  out_count_error;

  acct_scoreboard sb;
  bit             tx_idle_en;
  bit             rx_idle_en;
  bit             hold_req;

  shared_buffer_dynamic_threshold_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_byte_count       (in_byte_count),
    .in_queue_index      (in_queue_index),
    .in_port_index       (in_port_index),
    .in_sat_level        (in_sat_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_total_used      (out_total_used),
    .out_priority_used   (out_priority_used),
    .out_queue_limit     (out_queue_limit),
    .out_priority_limit  (out_priority_limit),
    .out_saturated_count (out_saturated_count),
    .out_count_error     (out_count_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic acct_beat_t make_beat(func_t f, logic [BYTES_W-1:0] bytes,
                                           logic [QUEUE_W-1:0] q, logic [PORT_W-1:0] port,
                                           logic lvl);
    acct_beat_t b;
    b.func  = f;
    b.bytes = bytes;
    b.queue = q;
    b.port  = port;
    b.lvl   = lvl;
    return b;
  endfunction

  function automatic acct_beat_t rand_beat();
    acct_beat_t b;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      b.func = FUNC_ENQ;
    else if (pick < 65) b.func = FUNC_DEQ;
    else if (pick < 90) b.func = FUNC_SAT;
    else                b.func = FUNC_QUERY;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: b.bytes = BYTES_W'($urandom_range(0, 1500));
      5, 6:          b.bytes = BYTES_W'($urandom_range(0, 8000));
      7, 8:          b.bytes = BYTES_W'($urandom);
      default:       b.bytes = ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
    b.queue = QUEUE_W'($urandom);
    b.port  = PORT_W'($urandom);
    b.lvl   = 1'($urandom);
    return b;
  endfunction

  function automatic logic [TABLE_W-1:0] rand_alpha_table();
    logic [TABLE_W-1:0] t;
    case ($urandom_range(0, 3))
      0: t = '0;
      1: t = '1;
      2: t = {$urandom, $urandom};
      default: begin
        // realistic alphas: up to 2.0
        for (int i = 0; i < TABLE_W / ALPHA_W; i++)
          t[ALPHA_W*i +: ALPHA_W] = ALPHA_W'($urandom_range(0, 32));
      end
    endcase
    return t;
  endfunction

  function automatic logic [CNT_W-1:0] rand_max_buffer();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CNT_MAX;
      2:       return CNT_W'($urandom);
      default: return CNT_W'($urandom_range(1, 40000));
    endcase
  endfunction

  // hold cfg_wr_en high; the caller lowers it after the last register
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(logic [CNT_W-1:0] mb, logic [TABLE_W-1:0] qa,
                              logic [TABLE_W-1:0] pa, logic [CNT_W-1:0] map);
    logic [CFG_DATA_W-1:0] d_max;
    logic [CFG_DATA_W-1:0] d_map;
    // junk above the 24-bit registers must be dropped
    d_max = {$urandom, $urandom};
    d_max[CNT_W-1:0] = mb;
    d_map = {$urandom, $urandom};
    d_map[CNT_W-1:0] = map;
    write_reg(CFG_MAX_BUFFER, d_max);
    write_reg(CFG_QUEUE_ALPHA, qa);
    write_reg(CFG_PRIO_ALPHA, pa);
    write_reg(CFG_QPRIO_MAP, d_map);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_beat(acct_beat_t b);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= b.func;
    in_byte_count  <= b.bytes;
    in_queue_index <= b.queue;
    in_port_index  <= b.port;
    in_sat_level   <= b.lvl;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_beat(rand_beat());
  endtask

  // touch every port-queue bit once, starting at a random pair; with skip_same
  // only the bits that would change are sent
  task automatic sat_sweep(logic lvl, bit skip_same);
    int                 start;
    int                 idx;
    logic [QUEUE_W-1:0] q;
    logic [PORT_W-1:0]  port;
    start = $urandom_range(0, NUM_PORTS * NUM_QUEUES - 1);
    for (int k = 0; k < NUM_PORTS * NUM_QUEUES; k++) begin
      idx  = (start + k) % (NUM_PORTS * NUM_QUEUES);
      q    = QUEUE_W'(idx % NUM_QUEUES);
      port = PORT_W'(idx / NUM_QUEUES);
      if (!skip_same || sb.sat_bits[port][q] != lvl)
        send_beat(make_beat(FUNC_SAT, BYTES_W'($urandom), q, port, lvl));
    end
  endtask

  // drop valid and let the block drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    send_beat(make_beat(FUNC_QUERY, '0, 0, 0, 1'b0));
    send_beat(make_beat(FUNC_ENQ, '0, 0, 0, 1'b0));
    send_beat(make_beat(FUNC_ENQ, '1, 7, 15, 1'b1));
    send_beat(make_beat(FUNC_ENQ, 1, 3, 0, 1'b0));
    // priority counter below zero
    send_beat(make_beat(FUNC_DEQ, 2, 3, 0, 1'b0));
    send_beat(make_beat(FUNC_DEQ, '1, 7, 0, 1'b0));
    // total below zero
    send_beat(make_beat(FUNC_DEQ, '1, 0, 0, 1'b0));
    send_beat(make_beat(FUNC_SAT, 0, 0, 0, 1'b1));
    send_beat(make_beat(FUNC_SAT, 0, 0, 0, 1'b1));
    send_beat(make_beat(FUNC_SAT, '1, 7, 15, 1'b1));
    send_beat(make_beat(FUNC_SAT, 0, 7, 15, 1'b0));
    send_beat(make_beat(FUNC_SAT, 0, 7, 15, 1'b0));
    // past max_buffer, then exactly full, then one byte free
    send_beat(make_beat(FUNC_ENQ, 12000, 5, 0, 1'b0));
    send_beat(make_beat(FUNC_QUERY, 0, 5, 15, 1'b1));
    send_beat(make_beat(FUNC_DEQ, 2000, 5, 0, 1'b0));
    send_beat(make_beat(FUNC_DEQ, 1, 5, 0, 1'b0));
    for (int q = 0; q < NUM_QUEUES; q++)
      send_beat(make_beat(FUNC_ENQ, BYTES_W'(100 * (q + 1)), QUEUE_W'(q), PORT_W'(q),
                          1'(q)));
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result(acct_report_t'({out_total_used, out_priority_used, out_queue_limit,
                                        out_priority_limit, out_saturated_count,
                                        out_count_error}));
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 7);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rst_n;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat accepted for %0d cycles", quiet);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req   = 1'b0;
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= CFG_MAX_BUFFER;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_QUERY;
    in_byte_count  <= '0;
    in_queue_index <= '0;
    in_port_index  <= '0;
    in_sat_level   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0:       program_regs('0, '1, '1, MAP_ALL_PRIO0);
        1:       program_regs(CNT_MAX, '0, '0, CNT_MAX);
        default: program_regs(rand_max_buffer(), rand_alpha_table(), rand_alpha_table(),
                              CNT_W'($urandom));
      endcase
      // back up the result side while beats keep coming
      if (ph == 2) hold_req = 1'b1;
      run_random(20);
    end

    // drive the total counter into its ceiling
    settle();
    program_regs(CNT_MAX, rand_alpha_table(), rand_alpha_table(), CNT_W'($urandom));
    repeat (260)
      send_beat(make_beat(FUNC_ENQ, BYTES_W'(16'hFFFF - $urandom_range(0, 15)),
                          QUEUE_W'($urandom), PORT_W'($urandom), 1'($urandom)));

    // move bits between priorities so the counts drift below zero and past the top
    settle();
    program_regs(rand_max_buffer(), rand_alpha_table(), rand_alpha_table(), MAP_ALL_PRIO1);
    sat_sweep(1'b0, 1'b1);
    settle();
    program_regs(rand_max_buffer(), rand_alpha_table(), rand_alpha_table(), MAP_ALL_PRIO0);
    sat_sweep(1'b1, 1'b0);
    settle();
    program_regs(rand_max_buffer(), rand_alpha_table(), rand_alpha_table(), MAP_ALL_PRIO1);
    sat_sweep(1'b0, 1'b0);
    settle();
    program_regs(rand_max_buffer(), rand_alpha_table(), rand_alpha_table(), MAP_ALL_PRIO0);
    sat_sweep(1'b1, 1'b0);

    settle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    program_regs(CNT_W'($urandom_range(1, 40000)), rand_alpha_table(), rand_alpha_table(),
                 CNT_W'($urandom));
    run_random(30);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
